// File: hw/rtl/serial_can_frame_deframer_macros.svh
// assertion macros shared by the deframer rtl
// expects clk and rst_n in the scope of use
`ifndef SERIAL_CAN_FRAME_DEFRAMER_MACROS_SVH
`define SERIAL_CAN_FRAME_DEFRAMER_MACROS_SVH

// implication checked on every clock edge outside reset
`define SCFD_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define SCFD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: hw/rtl/scfd_pkg.sv
// types, codes and the result decode function of the serial can deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scfd_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'h66;
    localparam logic [7:0] SYNC_SECOND  = 8'hCC;
    localparam logic [7:0] CMD_CAN      = 8'hB1;
    localparam logic [7:0] CMD_BAUD_CFG = 8'h92;
    localparam logic [7:0] CMD_BAUD     = 8'h93;
    localparam logic [7:0] CMD_FLT_SET  = 8'h98;
    localparam logic [7:0] CMD_FLT_CLR  = 8'h99;
    localparam logic [3:0] MAX_RESULTS  = 4'd12;
    // decoded bytes cover frame offsets 4 .. 18
    localparam int         DEC_BYTES    = 15;
    localparam logic [3:0] DEC_LAST     = 4'd14;

    typedef enum logic [2:0] {
        KIND_CAN      = 3'd0,
        KIND_BAUD_CFG = 3'd1,
        KIND_BAUD     = 3'd2,
        KIND_FLT_SET  = 3'd3,
        KIND_FLT_CLR  = 3'd4,
        KIND_OTHER    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_BODY  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_TAKE,
        S_CHECK,
        S_RRD,
        S_RWR,
        S_DRD,
        S_DCAP,
        S_EMIT,
        S_FLUSH
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  cmd_code;
        logic [15:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [7:0]  status_byte;
        logic [7:0]  filter_index;
        logic [10:0] baud_kbps;
        logic        clear_ok;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       prepend;
        logic       pop;
        logic [7:0] wdata;
    } queue_ctrl_t;

    // b[i] holds frame offset 4+i, zero past the frame end
    function automatic result_t decode(input logic [DEC_BYTES-1:0][7:0] b);
        result_t     r;
        logic [3:0]  n;
        logic [63:0] p;
        r = '0;
        p = '0;
        n = (b[6] > 8'd8) ? 4'd8 : b[6][3:0];
        r.cmd_code = b[0];
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n)
                p[8*i +: 8] = b[7+i];
        end
        case (b[0])
            CMD_CAN:
            begin
                r.kind    = KIND_CAN;
                r.can_id  = {b[4], b[5]};
                r.dlc     = n;
                r.payload = p;
            end
            CMD_BAUD_CFG:
            begin
                r.kind        = KIND_BAUD_CFG;
                r.status_byte = b[1];
            end
            CMD_BAUD:
            begin
                r.kind      = KIND_BAUD;
                r.baud_kbps = {1'b0, b[2], 2'b00} + {3'b000, b[2]};
            end
            CMD_FLT_SET:
            begin
                r.kind         = KIND_FLT_SET;
                r.status_byte  = b[1];
                r.filter_index = b[2];
            end
            CMD_FLT_CLR:
            begin
                r.kind        = KIND_FLT_CLR;
                r.status_byte = b[1];
                r.clear_ok    = (b[1] == 8'd0);
            end
            default:
                r.kind = KIND_OTHER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/scfd_queue.sv
// circular byte queue for pending and replayed bytes, with push at the tail
// and prepend at the head; uses scfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module scfd_queue #(
    parameter int QW = 7
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire scfd_pkg::queue_ctrl_t ctrl,
    output logic [7:0]               rdata,
    output logic                     empty
);
    import scfd_pkg::*;

    logic [7:0]    q_mem [2**QW];
    logic [QW-1:0] head_reg, head_next;
    logic [QW-1:0] tail_reg, tail_next;
    logic [QW-1:0] waddr;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        waddr     = tail_reg;
        if (ctrl.push)
            tail_next = tail_reg + 1'b1;
        if (ctrl.prepend)
        begin
            head_next = head_reg - 1'b1;
            waddr     = head_reg - 1'b1;
        end
        else if (ctrl.pop)
            head_next = head_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push || ctrl.prepend)
            q_mem[waddr] <= ctrl.wdata;
        if (ctrl.pop)
            rdata <= q_mem[head_reg];
    end

    assign empty = (head_reg == tail_reg);

endmodule

`default_nettype wire

// File: hw/rtl/serial_can_frame_deframer.sv
// Serial CAN adapter deframer. Each received byte runs through a small
// sequencer that takes one queued byte at a time through fetch (queue read),
// take (scan) and check; a byte that completes nothing passes idle, fetch,
// take and check before the input is ready again. A valid frame adds a read
// and a capture per decode byte 4..18 from the frame store; a rejected header
// or failed checksum replays stored bytes 1..n-1 into the byte queue, a read
// and a prepend each, before scanning resumes, and each replayed byte is then
// scanned again. One input byte can release several results; last marks the
// final one. A result waits in a hold register until it is known to be last.
`timescale 1ns / 1ps
`default_nettype none

module serial_can_frame_deframer #(
    parameter int MAX_FRAME_BYTES = 64,
    parameter int MIN_FRAME_BYTES = 6
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire  [7:0]        rx_byte,
    output logic              out_valid,
    input  wire               out_stall,
    output logic [2:0]        kind,
    output logic [7:0]        cmd_code,
    output logic [15:0]       can_id,
    output logic [3:0]        dlc,
    output logic [63:0]       payload,
    output logic [7:0]        status_byte,
    output logic [7:0]        filter_index,
    output logic [10:0]       baud_kbps,
    output logic              clear_ok,
    output logic              last
);
    import scfd_pkg::*;

    `include "serial_can_frame_deframer_macros.svh"

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int QW = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [16:0] MAX_TOTAL = 17'(MAX_FRAME_BYTES);
    localparam logic [16:0] MIN_TOTAL = 17'(MIN_FRAME_BYTES);

    state_t   state_reg, state_next;
    phase_t   phase_reg, phase_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic [CW-1:0] ri_reg, ri_next;
    logic [15:0]   len_reg, len_next;
    logic [7:0]    sum_reg, sum_next;
    logic [3:0]    di_reg, di_next;
    logic [3:0]    rcnt_reg, rcnt_next;
    logic [DEC_BYTES-1:0][7:0] dec_reg, dec_next;
    result_t       hold_reg, hold_next;
    logic          hold_vld_reg, hold_vld_next;
    result_t       out_reg, out_next;
    logic          out_vld_reg, out_vld_next;
    logic          last_reg, last_next;

    logic [7:0]    st_mem [MAX_FRAME_BYTES];
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic          st_rd;
    logic [AW-1:0] st_raddr;
    logic [7:0]    st_rdata;

    queue_ctrl_t   qc;
    logic [7:0]    q_rdata;
    logic          q_empty;

    logic [7:0]    b;
    logic [16:0]   total;
    logic [16:0]   lo_total;
    logic [CW-1:0] sc_inc;
    logic [4:0]    dec_off;
    logic          out_free;
    result_t       new_res;

    scfd_queue #(
        .QW(QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (qc),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign b        = q_rdata;
    assign total    = {1'b0, len_reg} + 17'd4;
    assign lo_total = {1'b0, len_reg[15:8], b} + 17'd4;
    assign sc_inc   = sc_reg + 1'b1;
    assign dec_off  = 5'd4 + {1'b0, di_reg};
    assign out_free = !out_vld_reg || !out_stall;
    assign new_res  = decode(dec_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_FETCH;
            S_FETCH:
                state_next = S_TAKE;
            S_TAKE:
            begin
                state_next = S_CHECK;
                case (phase_reg)
                    PH_LENLO:
                        if (lo_total < MIN_TOTAL || lo_total > MAX_TOTAL)
                            state_next = S_RRD;
                    PH_BODY:
                        if ({{(17-CW){1'b0}}, sc_inc} >= total)
                            state_next = (b == sum_reg) ? S_DRD : S_RRD;
                    default:
                        state_next = S_CHECK;
                endcase
            end
            S_CHECK:
                if (!q_empty)
                    state_next = S_FETCH;
                else if (hold_vld_reg)
                    state_next = S_FLUSH;
                else
                    state_next = S_IDLE;
            S_RRD:
                state_next = S_RWR;
            S_RWR:
                state_next = (ri_reg == CW'(1)) ? S_CHECK : S_RRD;
            S_DRD:
                state_next = S_DCAP;
            S_DCAP:
                state_next = (di_reg == DEC_LAST) ? S_EMIT : S_DRD;
            S_EMIT:
                if (rcnt_reg == MAX_RESULTS || !hold_vld_reg || out_free)
                    state_next = S_CHECK;
            S_FLUSH:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        phase_next    = phase_reg;
        sc_next       = sc_reg;
        ri_next       = ri_reg;
        len_next      = len_reg;
        sum_next      = sum_reg;
        di_next       = di_reg;
        rcnt_next     = rcnt_reg;
        dec_next      = dec_reg;
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        out_next      = out_reg;
        last_next     = last_reg;
        out_vld_next  = out_vld_reg && out_stall;
        in_stall      = 1'b1;
        st_we         = 1'b0;
        st_waddr      = sc_reg[AW-1:0];
        st_wdata      = b;
        st_rd         = 1'b0;
        st_raddr      = ri_reg[AW-1:0];
        qc            = '0;
        qc.wdata      = rx_byte;

        case (state_reg)
            S_IDLE:
            begin
                in_stall  = 1'b0;
                rcnt_next = '0;
                qc.push   = in_valid;
            end
            S_FETCH:
                qc.pop = 1'b1;
            S_TAKE:
            begin
                case (phase_reg)
                    PH_HUNT:
                        if (b == SYNC_FIRST)
                        begin
                            st_we      = 1'b1;
                            st_waddr   = '0;
                            sc_next    = CW'(1);
                            phase_next = PH_SYNC2;
                        end
                    PH_SYNC2:
                        if (b == SYNC_SECOND)
                        begin
                            st_we      = 1'b1;
                            sc_next    = sc_inc;
                            sum_next   = '0;
                            phase_next = PH_LENHI;
                        end
                        else if (b != SYNC_FIRST)
                        begin
                            sc_next    = '0;
                            sum_next   = '0;
                            phase_next = PH_HUNT;
                        end
                    PH_LENHI:
                    begin
                        st_we         = 1'b1;
                        sc_next       = sc_inc;
                        sum_next      = sum_reg + b;
                        len_next[15:8] = b;
                        phase_next    = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        st_we         = 1'b1;
                        sc_next       = sc_inc;
                        sum_next      = sum_reg + b;
                        len_next[7:0] = b;
                        phase_next    = PH_BODY;
                        if (lo_total < MIN_TOTAL || lo_total > MAX_TOTAL)
                        begin
                            // false header, replay everything after the first sync
                            ri_next    = sc_reg;
                            sc_next    = '0;
                            sum_next   = '0;
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_BODY:
                    begin
                        st_we   = 1'b1;
                        sc_next = sc_inc;
                        if ({{(17-CW){1'b0}}, sc_inc} >= total)
                        begin
                            di_next = '0;
                            if (b != sum_reg)
                            begin
                                ri_next    = sc_reg;
                                sc_next    = '0;
                                sum_next   = '0;
                                phase_next = PH_HUNT;
                            end
                        end
                        else
                            sum_next = sum_reg + b;
                    end
                    default:
                        phase_next = PH_HUNT;
                endcase
            end
            S_RRD:
                st_rd = 1'b1;
            S_RWR:
            begin
                qc.prepend = 1'b1;
                qc.wdata   = st_rdata;
                ri_next    = ri_reg - 1'b1;
            end
            S_DRD:
            begin
                st_rd    = 1'b1;
                st_raddr = AW'(dec_off);
            end
            S_DCAP:
            begin
                dec_next[di_reg] = ({12'd0, dec_off} < total) ? st_rdata : 8'd0;
                di_next          = di_reg + 1'b1;
            end
            S_EMIT:
            begin
                if (rcnt_reg == MAX_RESULTS)
                begin
                    sc_next    = '0;
                    sum_next   = '0;
                    phase_next = PH_HUNT;
                end
                else if (!hold_vld_reg || out_free)
                begin
                    if (hold_vld_reg)
                    begin
                        out_next     = hold_reg;
                        last_next    = 1'b0;
                        out_vld_next = 1'b1;
                    end
                    hold_next     = new_res;
                    hold_vld_next = 1'b1;
                    rcnt_next     = rcnt_reg + 1'b1;
                    sc_next       = '0;
                    sum_next      = '0;
                    phase_next    = PH_HUNT;
                end
            end
            S_FLUSH:
                if (out_free)
                begin
                    out_next      = hold_reg;
                    last_next     = 1'b1;
                    out_vld_next  = 1'b1;
                    hold_vld_next = 1'b0;
                end
            default:
                in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_HUNT;
            sc_reg       <= '0;
            ri_reg       <= '0;
            len_reg      <= '0;
            sum_reg      <= '0;
            di_reg       <= '0;
            rcnt_reg     <= '0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            sc_reg       <= sc_next;
            ri_reg       <= ri_next;
            len_reg      <= len_next;
            sum_reg      <= sum_next;
            di_reg       <= di_next;
            rcnt_reg     <= rcnt_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg  <= dec_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        if (st_rd)
            st_rdata <= st_mem[st_raddr];
    end

    assign out_valid    = out_vld_reg;
    assign kind         = out_reg.kind;
    assign cmd_code     = out_reg.cmd_code;
    assign can_id       = out_reg.can_id;
    assign dlc          = out_reg.dlc;
    assign payload      = out_reg.payload;
    assign status_byte  = out_reg.status_byte;
    assign filter_index = out_reg.filter_index;
    assign baud_kbps    = out_reg.baud_kbps;
    assign clear_ok     = out_reg.clear_ok;
    assign last         = last_reg;

    `SCFD_ASSERT_IMPL(a_idle_clean, !in_stall, !hold_vld_reg && q_empty,
        "input taken while a result or replay byte is pending")
    `SCFD_ASSERT_IMPL(a_flush_has_hold, state_reg == S_FLUSH, hold_vld_reg,
        "flush with no held result")
    `SCFD_ASSERT_IMPL(a_count_bound, 1'b1, sc_reg <= CW'(MAX_FRAME_BYTES),
        "stored count past frame store")
    `SCFD_ASSERT_NEXT(a_flush_last, state_reg == S_FLUSH && out_free,
        out_valid && last, "final result not marked last")

endmodule

`default_nettype wire

// File: verif/scfd_checker.sv
// checker for the serial can deframer: predicts the results of each byte transfer
// and compares them with the result transfers; depends on scfd_pkg
`timescale 1ns / 1ps

module scfd_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire  [7:0]  rx_byte,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire  [2:0]  kind,
    input  wire  [7:0]  cmd_code,
    input  wire  [15:0] can_id,
    input  wire  [3:0]  dlc,
    input  wire  [63:0] payload,
    input  wire  [7:0]  status_byte,
    input  wire  [7:0]  filter_index,
    input  wire  [10:0] baud_kbps,
    input  wire         clear_ok,
    input  wire         last,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import scfd_pkg::*;

    localparam int FRAME_MAX = 64;
    localparam int FRAME_MIN = 6;
    localparam int RESULT_CAP = 12;

    typedef struct {
        kind_t       kind;
        logic [7:0]  cmd;
        logic [15:0] id;
        logic [3:0]  dlen;
        logic [63:0] data;
        logic [7:0]  status;
        logic [7:0]  fidx;
        logic [10:0] kbps;
        logic        clr;
        logic        fin;
    } frame_result_t;

    logic [7:0]    frame_bytes [FRAME_MAX];
    int            n_stored;
    int            body_len;
    phase_t        phase;
    logic [7:0]    csum;
    logic [7:0]    replay_q [$];
    frame_result_t byte_results [$];
    frame_result_t expected_q [$];

    assign pending = expected_q.size();

    function automatic logic [7:0] frame_at(int off);
        if (off < body_len + 4 && off < FRAME_MAX)
            return frame_bytes[off];
        return 8'h00;
    endfunction

    function automatic void decode_frame();
        frame_result_t r;
        int            n;
        r = '{KIND_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        if (byte_results.size() >= RESULT_CAP)
            return;
        r.cmd = frame_at(4);
        case (r.cmd)
            CMD_CAN:
            begin
                n = frame_at(10);
                if (n > 8)
                    n = 8;
                r.kind = KIND_CAN;
                r.id = {frame_at(8), frame_at(9)};
                r.dlen = 4'(n);
                for (int i = 0; i < n; i++)
                    r.data[8*i +: 8] = frame_at(11 + i);
            end
            CMD_BAUD_CFG:
            begin
                r.kind = KIND_BAUD_CFG;
                r.status = frame_at(5);
            end
            CMD_BAUD:
            begin
                r.kind = KIND_BAUD;
                r.kbps = 11'(frame_at(6) * 5);
            end
            CMD_FLT_SET:
            begin
                r.kind = KIND_FLT_SET;
                r.status = frame_at(5);
                r.fidx = frame_at(6);
            end
            CMD_FLT_CLR:
            begin
                r.kind = KIND_FLT_CLR;
                r.status = frame_at(5);
                r.clr = (frame_at(5) == 8'h00);
            end
            default:
                r.kind = KIND_OTHER;
        endcase
        byte_results.insert(byte_results.size(), r);
    endfunction

    function automatic void restart_hunt();
        phase = PH_HUNT;
        n_stored = 0;
        csum = 8'h00;
    endfunction

    // false header or bad checksum: rescan everything after the first sync byte
    function automatic void rescan_header();
        logic [7:0] head [$];
        for (int i = 1; i < n_stored && i < FRAME_MAX; i++)
            head.insert(head.size(), frame_bytes[i]);
        replay_q = {head, replay_q};
        restart_hunt();
    endfunction

    function automatic void store_byte(logic [7:0] b);
        if (n_stored < FRAME_MAX)
            frame_bytes[n_stored] = b;
        n_stored++;
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        case (phase)
            PH_HUNT:
                if (b == SYNC_FIRST)
                begin
                    n_stored = 0;
                    store_byte(b);
                    phase = PH_SYNC2;
                end
            PH_SYNC2:
                if (b == SYNC_SECOND)
                begin
                    store_byte(b);
                    csum = 8'h00;
                    phase = PH_LENHI;
                end
                else if (b != SYNC_FIRST)
                    restart_hunt();
            PH_LENHI:
            begin
                store_byte(b);
                csum += b;
                phase = PH_LENLO;
            end
            PH_LENLO:
            begin
                store_byte(b);
                csum += b;
                body_len = {frame_bytes[2], b};
                if (body_len + 4 < FRAME_MIN || body_len + 4 > FRAME_MAX)
                    rescan_header();
                else
                    phase = PH_BODY;
            end
            default:
            begin
                store_byte(b);
                if (n_stored >= body_len + 4)
                begin
                    if (b == csum)
                    begin
                        decode_frame();
                        restart_hunt();
                    end
                    else
                        rescan_header();
                end
                else
                    csum += b;
            end
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        byte_results.delete();
        replay_q.delete();
        replay_q.insert(0, b);
        while (replay_q.size() > 0)
            scan_byte(replay_q.pop_front());
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].fin = 1'b1;
        foreach (byte_results[i])
            expected_q.insert(expected_q.size(), byte_results[i]);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t e;
        if (!rst_n)
        begin
            restart_hunt();
            body_len = 0;
            expected_q.delete();
            fail_count = 0;
            checked = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_byte(rx_byte);
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result transfer", kind, 0);
                else
                begin
                    e = expected_q.pop_front();
                    if (kind != e.kind) report_mismatch("kind", kind, e.kind);
                    if (cmd_code != e.cmd) report_mismatch("cmd_code", cmd_code, e.cmd);
                    if (can_id != e.id) report_mismatch("can_id", can_id, e.id);
                    if (dlc != e.dlen) report_mismatch("dlc", dlc, e.dlen);
                    if (payload != e.data) report_mismatch("payload", payload, e.data);
                    if (status_byte != e.status)
                        report_mismatch("status_byte", status_byte, e.status);
                    if (filter_index != e.fidx)
                        report_mismatch("filter_index", filter_index, e.fidx);
                    if (baud_kbps != e.kbps) report_mismatch("baud_kbps", baud_kbps, e.kbps);
                    if (clear_ok != e.clr) report_mismatch("clear_ok", clear_ok, e.clr);
                    if (last != e.fin) report_mismatch("last", last, e.fin);
                end
            end
        end
    end

endmodule

// File: verif/tb_top.sv
// top of the serial can deframer testbench: clock, reset, byte stimulus and verdict
// depends on scfd_pkg, serial_can_frame_deframer and scfd_checker
`timescale 1ns / 1ps

module tb_top;
    import scfd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  cmd_code;
    logic [15:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [7:0]  status_byte;
    logic [7:0]  filter_index;
    logic [10:0] baud_kbps;
    logic        clear_ok;
    logic        last;
    int          fail_count;
    int          pending;
    int          checked;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_done = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          cycles = 0;

    always #2 clk = ~clk;

    serial_can_frame_deframer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .cmd_code(cmd_code), .can_id(can_id), .dlc(dlc),
        .payload(payload), .status_byte(status_byte), .filter_index(filter_index),
        .baud_kbps(baud_kbps), .clear_ok(clear_ok), .last(last)
    );

    scfd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .cmd_code(cmd_code), .can_id(can_id), .dlc(dlc),
        .payload(payload), .status_byte(status_byte), .filter_index(filter_index),
        .baud_kbps(baud_kbps), .clear_ok(clear_ok), .last(last),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_done)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_done++;
        end
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic logic [7:0] CMD_OTHER_PAD();
        return 8'h42;
    endfunction

    task automatic send_byte(logic [7:0] b);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // frame of len+4 bytes; body[0] lands at offset 4, checksum is the last byte
    task automatic send_frame(logic [15:0] len, logic [7:0] body [$], bit bad_sum);
        logic [7:0] sum;
        sum = len[15:8] + len[7:0];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        for (int i = 0; i + 1 < len; i++)
        begin
            send_byte(i < body.size() ? body[i] : 8'h00);
            sum += (i < body.size() ? body[i] : 8'h00);
        end
        send_byte(bad_sum ? sum ^ 8'(1 << $urandom_range(7)) : sum);
        frames_sent++;
    endtask

    task automatic send_random_frame(bit bad_sum);
        logic [7:0] body [$];
        logic [15:0] len;
        int pick;
        len = ($urandom_range(99) < 85) ? 16'($urandom_range(2, 16))
                                        : 16'($urandom_range(17, 60));
        pick = $urandom_range(6);
        for (int i = 0; i + 1 < len; i++)
            body.insert(body.size(), 8'($urandom_range(255)));
        if (body.size() > 0)
            case (pick)
                0: body[0] = CMD_CAN;
                1: body[0] = CMD_BAUD_CFG;
                2: body[0] = CMD_BAUD;
                3: body[0] = CMD_FLT_SET;
                4: body[0] = CMD_FLT_CLR;
                5: body[0] = CMD_CAN;
                default: ;
            endcase
        if (body.size() > 6 && $urandom_range(1))
            body[6] = 8'($urandom_range(9));
        if (body.size() > 1 && $urandom_range(3) == 0)
            body[1] = 8'h00;
        send_frame(len, body, bad_sum);
    endtask

    task automatic run_random(int n_bytes);
        int stop_at;
        int r;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_random_frame(1'b0);
            else if (r < 80)
                send_random_frame(1'b1);
            else if (r < 88)
            begin
                // header with a random, usually out of range length
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(8'($urandom_range(255)));
                send_byte(8'($urandom_range(255)));
            end
            else
                repeat ($urandom_range(1, 5))
                    send_byte($urandom_range(7) == 0 ? SYNC_FIRST : 8'($urandom_range(255)));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] body [$];
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every command, min and max frame sizes, sync corner cases
        body = {CMD_CAN, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                8'h01, 8'h80, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h7F, 8'hFE};
        send_frame(16'd16, body, 1'b0);
        body = {CMD_CAN, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00};
        send_frame(16'd8, body, 1'b0);
        body = {CMD_BAUD_CFG, 8'hA5};
        send_frame(16'd3, body, 1'b0);
        body = {CMD_BAUD, 8'h00, 8'hFF};
        send_frame(16'd4, body, 1'b0);
        body = {CMD_FLT_SET, 8'h01, 8'hFF};
        send_frame(16'd4, body, 1'b0);
        body = {CMD_FLT_CLR, 8'h00};
        send_frame(16'd3, body, 1'b0);
        body = {CMD_FLT_CLR, 8'hFF};
        send_frame(16'd3, body, 1'b0);
        body = {8'h00};
        send_frame(16'd2, body, 1'b0);
        body.delete();
        send_frame(16'd60, body, 1'b0);
        // repeated first sync byte
        send_byte(SYNC_FIRST);
        body = {CMD_BAUD, 8'h00, 8'h07};
        send_frame(16'd4, body, 1'b0);
        // lengths just outside the bounds, and the largest length
        send_byte(SYNC_FIRST); send_byte(SYNC_SECOND); send_byte(8'h00); send_byte(8'd1);
        send_byte(SYNC_FIRST); send_byte(SYNC_SECOND); send_byte(8'h00); send_byte(8'd61);
        send_byte(SYNC_FIRST); send_byte(SYNC_SECOND); send_byte(8'hFF); send_byte(8'hFF);
        // bad checksum hiding a good frame inside its body
        body = {CMD_OTHER_PAD(), SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h02, CMD_BAUD_CFG, 8'h94};
        send_frame(16'd8, body, 1'b1);
        drain();

        idle_pct = 0;  stall_pct = 0;  run_random(100);
        hold_req++;
        run_random(40);
        drain();
        idle_pct = 82; stall_pct = 0;  run_random(65);
        drain();
        idle_pct = 0;  stall_pct = 82; run_random(65);
        drain();
        idle_pct = 25; stall_pct = 25; run_random(65);
        @(negedge clk);
        in_valid <= 1'b0;
        drain();

        $display("sent %0d bytes with %0d framed sequences, checked %0d result transfers",
                 bytes_sent, frames_sent, checked);
        $display("covered all commands, size bounds, bad checksums, false headers and stalls");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
